>>> rtl/smfp_pkg.sv
// Shared types and constants for the servo move frame parser.
// No dependencies; used by the decoder, the result buffer and the top level.
package smfp_pkg;

	localparam int unsigned SERVO_COUNT = 6;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] LEN_SINGLE = 8'h08;
	localparam logic [7:0] LEN_MULTI  = 8'h17;

	localparam logic [1:0] STATUS_INVALID = 2'd0;
	localparam logic [1:0] STATUS_SINGLE  = 2'd1;
	localparam logic [1:0] STATUS_MULTI   = 2'd2;

	typedef logic [SERVO_COUNT-1:0][15:0] goal_vec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] move_time;
		goal_vec_t   goal;
	} result_t;

endpackage

>>> rtl/smfp_decoder.sv
// Frame decoder: per-byte state update and result formation in one pass.
// Depends on smfp_pkg.
module smfp_decoder import smfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  frame_byte,
	input  logic        frame_start,
	output logic        emit,
	output result_t     result
);

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_HEADER = 2'd1;
	localparam logic [1:0] MODE_SINGLE = 2'd2;
	localparam logic [1:0] MODE_MULTI  = 2'd3;

	logic [1:0]  mode_q, mode_n;
	logic [4:0]  pos_q, pos_n;
	logic        hdr_ok_q, hdr_ok_n;
	logic        ids_ok_q, ids_ok_n;
	logic [7:0]  single_id_q, single_id_n;
	logic [7:0]  low_q, low_n;
	goal_vec_t   goal_q, goal_n;
	logic [15:0] time_q, time_n;
	goal_vec_t   stg_goal_q, stg_goal_n;
	logic [15:0] stg_time_q, stg_time_n;

	logic [1:0]  mode_c;
	logic [4:0]  pos_c;
	logic        hdr_ok_c, ids_ok_c;
	logic [4:0]  off;
	logic [2:0]  slot;
	logic [1:0]  phase;
	logic [2:0]  sid_idx;
	logic [15:0] word;

	// Split the offset into the id/goal triplets: slot k, phase 0 id, 1 low, 2 high.
	always_comb begin
		off = pos_c - 5'd7;
		if (off >= 5'd15)
			slot = 3'd5;
		else if (off >= 5'd12)
			slot = 3'd4;
		else if (off >= 5'd9)
			slot = 3'd3;
		else if (off >= 5'd6)
			slot = 3'd2;
		else if (off >= 5'd3)
			slot = 3'd1;
		else
			slot = 3'd0;
		phase = 2'(off - 5'd3 * {2'd0, slot});
	end

	always_comb begin
		mode_c      = frame_start ? MODE_HEADER : mode_q;
		pos_c       = frame_start ? 5'd0 : pos_q;
		hdr_ok_c    = frame_start ? 1'b0 : hdr_ok_q;
		ids_ok_c    = frame_start ? 1'b1 : ids_ok_q;
		word        = {frame_byte, low_q};
		sid_idx     = single_id_q[2:0] - 3'd1;
		mode_n      = mode_q;
		pos_n       = pos_q;
		hdr_ok_n    = hdr_ok_q;
		ids_ok_n    = ids_ok_q;
		single_id_n = single_id_q;
		low_n       = low_q;
		goal_n      = goal_q;
		time_n      = time_q;
		stg_goal_n  = stg_goal_q;
		stg_time_n  = stg_time_q;
		emit        = 1'b0;
		result.status = STATUS_INVALID;
		if (accept) begin
			mode_n   = mode_c;
			pos_n    = pos_c;
			hdr_ok_n = hdr_ok_c;
			ids_ok_n = ids_ok_c;
			if (mode_c != MODE_IDLE) begin
				pos_n = pos_c + 5'd1;
				case (mode_c)
					MODE_HEADER: begin
						if (pos_c == 5'd0) begin
							if (frame_byte != HDR_BYTE)
								emit = 1'b1;
							else
								hdr_ok_n = 1'b1;
						end else if (pos_c == 5'd1) begin
							if (frame_byte != HDR_BYTE || !hdr_ok_c)
								emit = 1'b1;
						end else if (frame_byte == LEN_SINGLE) begin
							mode_n = MODE_SINGLE;
						end else if (frame_byte == LEN_MULTI) begin
							mode_n = MODE_MULTI;
						end else begin
							emit = 1'b1;
						end
					end
					MODE_SINGLE: begin
						if (pos_c == 5'd7) begin
							single_id_n = frame_byte;
						end else if (pos_c == 5'd8) begin
							low_n = frame_byte;
						end else if (pos_c == 5'd9) begin
							if (single_id_q >= 8'd1 && single_id_q <= 8'd6)
								goal_n[sid_idx] = word;
							emit          = 1'b1;
							result.status = STATUS_SINGLE;
						end
					end
					MODE_MULTI: begin
						if (pos_c == 5'd5) begin
							low_n = frame_byte;
						end else if (pos_c == 5'd6) begin
							stg_time_n = word;
						end else if (pos_c >= 5'd7 && pos_c <= 5'd24) begin
							case (phase)
								2'd0: begin
									if (frame_byte != {5'd0, slot} + 8'd1)
										ids_ok_n = 1'b0;
								end
								2'd1: low_n = frame_byte;
								default: begin
									stg_goal_n[slot] = word;
									if (slot == 3'd5) begin
										// Commit the staged set only if every id matched.
										if (ids_ok_c) begin
											time_n = stg_time_q;
											goal_n = stg_goal_n;
										end
										emit          = 1'b1;
										result.status = STATUS_MULTI;
									end
								end
							endcase
						end
					end
					default: ;
				endcase
				if (emit)
					mode_n = MODE_IDLE;
			end
		end
		result.move_time = time_n;
		result.goal      = goal_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pos_q       <= 5'd0;
			hdr_ok_q    <= 1'b0;
			ids_ok_q    <= 1'b1;
			single_id_q <= 8'd0;
			low_q       <= 8'd0;
			goal_q      <= '0;
			time_q      <= 16'd0;
		end else begin
			mode_q      <= mode_n;
			pos_q       <= pos_n;
			hdr_ok_q    <= hdr_ok_n;
			ids_ok_q    <= ids_ok_n;
			single_id_q <= single_id_n;
			low_q       <= low_n;
			goal_q      <= goal_n;
			time_q      <= time_n;
		end
	end

	// Staged values are always written before any commit reads them.
	always_ff @(posedge clk) begin
		stg_goal_q <= stg_goal_n;
		stg_time_q <= stg_time_n;
	end

endmodule

>>> rtl/smfp_result_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on smfp_pkg.
module smfp_result_buf import smfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop       = out_valid_q & out_ready;
	assign space     = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

endmodule

>>> rtl/servo_move_frame_parser.sv
// Top level of the servo move frame parser.
// Depends on smfp_pkg, smfp_decoder and smfp_result_buf.
//
// Usage:
//   Input channel (in_valid/in_ready, frame_byte, frame_start) carries one
//   frame byte per request; frame_start marks the first byte of a frame.
//   Header 0x55 0x55, then length 8 (single servo: id, goal low, goal high
//   at bytes 7..9) or length 0x17 (move time at bytes 5,6, then six
//   id/low/high triplets that must carry ids 1..6 in order to commit).
//   Output channel (out_valid/out_ready) carries one request per decided
//   frame: status (0 invalid, 1 single, 2 all-servo) with the kept move
//   time and six goals as they stand after that frame.
//   Throughput: one byte per cycle while the skid register is free, set by
//   the single-pass decoder that updates all frame state from the byte in
//   the cycle it is accepted. The result is formed from the deciding byte
//   and registered in the output register, or in the skid register if busy.
//   Receiver stall: a waiting result holds in the output register while
//   bytes keep flowing; a second result goes to the skid register, and
//   in_ready drops only while the skid register is full.
//   Reset: goals and move time clear to zero, the parser goes idle and
//   ignores bytes until a frame_start, and both buffer entries empty.
module servo_move_frame_parser import smfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] move_time,
	output logic [15:0] goal_one,
	output logic [15:0] goal_two,
	output logic [15:0] goal_three,
	output logic [15:0] goal_four,
	output logic [15:0] goal_five,
	output logic [15:0] goal_six
);

	logic    accept;
	logic    emit;
	logic    space;
	result_t dec_result;
	result_t out_data;

	// Advance the parser on every accepted request.
	assign in_ready = space;
	assign accept   = in_valid & space;

	smfp_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_byte  (frame_byte),
		.frame_start (frame_start),
		.emit        (emit),
		.result      (dec_result)
	);

	// Hold results here until the receiver takes them.
	smfp_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (dec_result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign status     = out_data.status;
	assign move_time  = out_data.move_time;
	assign goal_one   = out_data.goal[0];
	assign goal_two   = out_data.goal[1];
	assign goal_three = out_data.goal[2];
	assign goal_four  = out_data.goal[3];
	assign goal_five  = out_data.goal[4];
	assign goal_six   = out_data.goal[5];

endmodule

>>> verif/smfp_checker.sv
// Checker for the servo move frame parser: watches both channels, predicts results.
// Depends on smfp_pkg; instantiated by tb beside the block.
// Hands its mismatch count, pending results and status tallies to tb.
module smfp_checker import smfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        frame_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [15:0] move_time,
	input  logic [15:0] goal_one,
	input  logic [15:0] goal_two,
	input  logic [15:0] goal_three,
	input  logic [15:0] goal_four,
	input  logic [15:0] goal_five,
	input  logic [15:0] goal_six,
	output int          mismatch_count,
	output int          pending_results,
	output int          invalid_seen,
	output int          single_seen,
	output int          multi_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {PARSE_IDLE, PARSE_HEADER, PARSE_SINGLE, PARSE_MULTI} parse_mode_e;

	// Parser state as seen from outside
	goal_vec_t   kept_goals;
	goal_vec_t   staged_goals;
	logic [15:0] kept_time;
	logic [15:0] staged_time;
	logic [4:0]  byte_pos;
	parse_mode_e mode;
	logic        hdr_seen;
	logic        ids_ok;
	logic [7:0]  single_id;
	logic [7:0]  low_hold;

	result_t     frame_results_q[$];
	result_t     want;
	goal_vec_t   got_goals;
	bit          decided;
	logic [1:0]  decided_status;
	int          errors;
	int          n_invalid;
	int          n_single;
	int          n_multi;
	int          pending;

	assign mismatch_count  = errors;
	assign pending_results = pending;
	assign invalid_seen    = n_invalid;
	assign single_seen     = n_single;
	assign multi_seen      = n_multi;

	// Advance the parser by one accepted byte; report whether the frame got decided.
	task automatic parse_byte(input logic [7:0] b, input logic start, output bit done,
			output logic [1:0] st);
		logic [4:0] pos;
		int k;
		int r;
		done = 1'b0;
		st = STATUS_INVALID;
		if (start) begin
			byte_pos = '0;
			mode = PARSE_HEADER;
			hdr_seen = 1'b0;
			ids_ok = 1'b1;
		end
		if (mode == PARSE_IDLE)
			return;
		pos = byte_pos;
		byte_pos = byte_pos + 5'd1;
		case (mode)
			PARSE_HEADER: begin
				if (pos == 5'd0) begin
					if (b != HDR_BYTE)
						done = 1'b1;
					else
						hdr_seen = 1'b1;
				end else if (pos == 5'd1) begin
					if (b != HDR_BYTE || !hdr_seen)
						done = 1'b1;
				end else if (b == LEN_SINGLE) begin
					mode = PARSE_SINGLE;
				end else if (b == LEN_MULTI) begin
					mode = PARSE_MULTI;
				end else begin
					done = 1'b1;
				end
			end
			PARSE_SINGLE: begin
				if (pos == 5'd7) begin
					single_id = b;
				end else if (pos == 5'd8) begin
					low_hold = b;
				end else if (pos == 5'd9) begin
					if (single_id >= 8'd1 && single_id <= 8'(SERVO_COUNT))
						kept_goals[single_id - 8'd1] = {b, low_hold};
					done = 1'b1;
					st = STATUS_SINGLE;
				end
			end
			default: begin
				if (pos == 5'd5) begin
					low_hold = b;
				end else if (pos == 5'd6) begin
					staged_time = {b, low_hold};
				end else if (pos >= 5'd7 && pos <= 5'd24) begin
					k = (int'(pos) - 7) / 3;
					r = (int'(pos) - 7) % 3;
					if (r == 0) begin
						if (b != 8'(k + 1))
							ids_ok = 1'b0;
					end else if (r == 1) begin
						low_hold = b;
					end else begin
						staged_goals[k] = {b, low_hold};
						if (k == SERVO_COUNT - 1) begin
							// commit only when every id came in order
							if (ids_ok) begin
								kept_time = staged_time;
								kept_goals = staged_goals;
							end
							done = 1'b1;
							st = STATUS_MULTI;
						end
					end
				end
			end
		endcase
		if (done)
			mode = PARSE_IDLE;
	endtask

	function automatic void check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_goals = '0;
			staged_goals = '0;
			kept_time = '0;
			staged_time = '0;
			byte_pos = '0;
			mode = PARSE_IDLE;
			hdr_seen = 1'b0;
			ids_ok = 1'b1;
			single_id = '0;
			low_hold = '0;
			frame_results_q.delete();
			pending = 0;
		end else begin
			// a result leaving now belongs to a byte taken at an earlier edge
			if (out_valid && out_ready) begin
				if (frame_results_q.size() == 0) begin
					$error("status: expected none, got %0d", status);
					errors++;
				end else begin
					want = frame_results_q.pop_front();
					got_goals = {goal_six, goal_five, goal_four, goal_three, goal_two, goal_one};
					check_field("status", 16'(want.status), 16'(status));
					check_field("move_time", want.move_time, move_time);
					check_field("goal_one", want.goal[0], got_goals[0]);
					check_field("goal_two", want.goal[1], got_goals[1]);
					check_field("goal_three", want.goal[2], got_goals[2]);
					check_field("goal_four", want.goal[3], got_goals[3]);
					check_field("goal_five", want.goal[4], got_goals[4]);
					check_field("goal_six", want.goal[5], got_goals[5]);
					case (want.status)
						STATUS_SINGLE: n_single++;
						STATUS_MULTI:  n_multi++;
						default:       n_invalid++;
					endcase
				end
			end
			if (in_valid && in_ready) begin
				parse_byte(frame_byte, frame_start, decided, decided_status);
				if (decided) begin
					want.status = decided_status;
					want.move_time = kept_time;
					want.goal = kept_goals;
					frame_results_q.push_back(want);
				end
			end
			pending = frame_results_q.size();
		end
	end

endmodule

>>> verif/tb.sv
// Top of the servo move frame parser testbench: clock, reset, stimulus and verdict.
// Depends on smfp_pkg, servo_move_frame_parser and smfp_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smfp_pkg::*;

	localparam int ITEM_TARGET = 1900;    // frame bytes to drive, stray bytes excluded
	localparam int CYCLE_LIMIT = 400000;  // watchdog, far beyond the slowest legal run
	localparam int DRAIN_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int LONG_HOLD   = 300;     // receiver hold-off that fills the buffer
	localparam int HOLD_AFTER  = 40;      // results taken before the hold-off

	typedef enum int {
		FR_MULTI_OK, FR_MULTI_BAD_IDS, FR_SINGLE_OK, FR_SINGLE_BAD_ID,
		FR_BAD_HEADER, FR_BAD_LENGTH, FR_CUT_SHORT, FR_STRAY
	} frame_kind_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  frame_byte = '0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] move_time;
	logic [15:0] goal_one;
	logic [15:0] goal_two;
	logic [15:0] goal_three;
	logic [15:0] goal_four;
	logic [15:0] goal_five;
	logic [15:0] goal_six;

	int          mismatch_count;
	int          pending_results;
	int          invalid_seen;
	int          single_seen;
	int          multi_seen;
	int          cycle_count = 0;
	int          frame_bytes = 0;
	int          stray_bytes = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;
	logic [7:0]  frame_buf[$];

	servo_move_frame_parser i_dut (.*);

	smfp_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frame_byte     (frame_byte),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.move_time      (move_time),
		.goal_one       (goal_one),
		.goal_two       (goal_two),
		.goal_three     (goal_three),
		.goal_four      (goal_four),
		.goal_five      (goal_five),
		.goal_six       (goal_six),
		.mismatch_count (mismatch_count),
		.pending_results(pending_results),
		.invalid_seen   (invalid_seen),
		.single_seen    (single_seen),
		.multi_seen     (multi_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: give up on a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("no progress after %0d cycles", CYCLE_LIMIT);
			$display("servo_move_frame_parser: mismatch");
			$finish;
		end
	end

	function automatic logic [7:0] rnd8();
		return 8'($urandom);
	endfunction

	// Favor the extremes of a 16-bit goal or time now and then.
	function automatic logic [15:0] rnd16();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one byte as a request; hold valid and payload until it is taken.
	// Valid drops only ahead of an idle gap, so it never toggles within one step.
	task automatic send_byte(input logic [7:0] b, input logic start);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_byte <= b;
		frame_start <= start;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Send the first upto bytes of frame_buf; the first one opens the frame.
	task automatic send_frame(input int upto);
		int i;
		for (i = 0; i < upto && i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == 0);
		frame_bytes += i;
	endtask

	task automatic send_stray(input int count);
		repeat (count) send_byte(rnd8(), 1'b0);
		stray_bytes += count;
	endtask

	task automatic build_header(input logic [7:0] len);
		frame_buf.delete();
		frame_buf.push_back(HDR_BYTE);
		frame_buf.push_back(HDR_BYTE);
		frame_buf.push_back(len);
		frame_buf.push_back(rnd8());
		frame_buf.push_back(rnd8());
	endtask

	// Single-servo frame: bytes 5 and 6 carry junk, then id and little-endian goal.
	task automatic build_single(input logic [7:0] id, input logic [15:0] goal);
		build_header(LEN_SINGLE);
		frame_buf.push_back(rnd8());
		frame_buf.push_back(rnd8());
		frame_buf.push_back(id);
		frame_buf.push_back(goal[7:0]);
		frame_buf.push_back(goal[15:8]);
	endtask

	// All-servo frame: move time, then id/low/high per servo; a set bad_ids bit
	// swaps that servo's id for any other value.
	task automatic build_multi(input logic [15:0] mtime, input goal_vec_t goals,
			input logic [5:0] bad_ids);
		int k;
		logic [7:0] id;
		build_header(LEN_MULTI);
		frame_buf.push_back(mtime[7:0]);
		frame_buf.push_back(mtime[15:8]);
		for (k = 0; k < SERVO_COUNT; k++) begin
			id = 8'(k + 1);
			if (bad_ids[k])
				id = 8'(k + 1 + $urandom_range(1, 255));
			frame_buf.push_back(id);
			frame_buf.push_back(goals[k][7:0]);
			frame_buf.push_back(goals[k][15:8]);
		end
	endtask

	function automatic goal_vec_t rnd_goals();
		goal_vec_t g;
		for (int k = 0; k < SERVO_COUNT; k++)
			g[k] = rnd16();
		return g;
	endfunction

	// Receiver: draw a stall per result; once, hold off long enough to back up the block.
	initial begin : rx_side
		int stall;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			if (taken == HOLD_AFTER)
				stall = LONG_HOLD;
			else
				stall = rx_burst ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			taken++;
		end
	end

	initial begin : tx_side
		frame_kind_e kind;
		logic [7:0] len;
		int drained;
		int leftover;
		int fails;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray byte while idle, each way a frame can fail, both
		// frame kinds with extreme values, a bad id of each kind, a cut-short
		// frame and bytes trailing a decided frame.
		send_stray(1);
		frame_buf.delete();
		frame_buf.push_back(8'h00);
		send_frame(1);
		frame_buf.delete();
		frame_buf.push_back(HDR_BYTE);
		frame_buf.push_back(8'hAA);
		send_frame(2);
		build_header(8'hFF);
		send_frame(3);
		build_single(8'd1, 16'hFFFF);
		send_frame(frame_buf.size());
		build_single(8'd6, 16'h0000);
		send_frame(frame_buf.size());
		build_single(8'd7, 16'h1234);
		send_frame(frame_buf.size());
		send_stray(2);
		build_multi(16'hFFFF, {16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A, 16'h0001, 16'h8000},
			6'b000000);
		send_frame(frame_buf.size());
		build_multi(16'h0000, '0, 6'b100000);
		send_frame(frame_buf.size());
		build_single(8'd2, 16'hBEEF);
		send_frame(5);
		build_single(8'd3, 16'hCAFE);
		send_frame(frame_buf.size());

		// Random: mostly well-formed frames with random content, the rest broken.
		while (frame_bytes < ITEM_TARGET) begin
			case ($urandom_range(0, 99)) inside
				[0:29]:  kind = FR_MULTI_OK;
				[30:39]: kind = FR_MULTI_BAD_IDS;
				[40:59]: kind = FR_SINGLE_OK;
				[60:64]: kind = FR_SINGLE_BAD_ID;
				[65:72]: kind = FR_BAD_HEADER;
				[73:79]: kind = FR_BAD_LENGTH;
				[80:89]: kind = FR_CUT_SHORT;
				default: kind = FR_STRAY;
			endcase
			case (kind)
				FR_MULTI_OK: begin
					build_multi(rnd16(), rnd_goals(), 6'b000000);
					send_frame(frame_buf.size());
				end
				FR_MULTI_BAD_IDS: begin
					build_multi(rnd16(), rnd_goals(), 6'($urandom_range(1, 63)));
					send_frame(frame_buf.size());
				end
				FR_SINGLE_OK: begin
					build_single(8'($urandom_range(1, SERVO_COUNT)), rnd16());
					send_frame(frame_buf.size());
				end
				FR_SINGLE_BAD_ID: begin
					len = rnd8();
					if (len >= 8'd1 && len <= 8'(SERVO_COUNT))
						len = len + 8'd100;
					build_single(len, rnd16());
					send_frame(frame_buf.size());
				end
				FR_BAD_HEADER: begin
					frame_buf.delete();
					if ($urandom_range(0, 1))
						frame_buf.push_back(HDR_BYTE);
					frame_buf.push_back(8'(HDR_BYTE + $urandom_range(1, 255)));
					send_frame(frame_buf.size());
				end
				FR_BAD_LENGTH: begin
					len = rnd8();
					if (len == LEN_SINGLE || len == LEN_MULTI)
						len = ~len;
					build_header(len);
					send_frame(3);
				end
				FR_CUT_SHORT: begin
					if ($urandom_range(0, 1))
						build_multi(rnd16(), rnd_goals(), 6'($urandom));
					else
						build_single(rnd8(), rnd16());
					send_frame($urandom_range(1, frame_buf.size() - 1));
				end
				default: send_stray($urandom_range(1, 4));
			endcase
		end
		in_valid <= 1'b0;

		// Drain: let the last byte land in the checker, then wait out the results.
		@(posedge clk);
		for (drained = 0; drained < DRAIN_LIMIT && pending_results != 0; drained++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		leftover = pending_results;
		if (leftover != 0)
			$error("%0d expected results never arrived", leftover);
		fails = mismatch_count + leftover;

		$display("drove %0d frame bytes and %0d stray bytes in %0d cycles", frame_bytes,
			stray_bytes, cycle_count);
		$display("checked results: %0d invalid, %0d single-servo, %0d all-servo",
			invalid_seen, single_seen, multi_seen);
		if (fails == 0)
			$display("servo_move_frame_parser: match");
		else
			$display("servo_move_frame_parser: mismatch");
		$finish;
	end

endmodule
